@@ sv/lqr_pkg.sv @@
// Shared types, codes and sizes for the linear queue with replace.
package lqr_pkg;

	// Queue size and index width
	localparam int DEPTH = 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [31:0] word_t;

	// Command codes on the input channel
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_REPLACE = 2'd2;

	// Status codes on the output channel
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	// Decoded operation handed from the front end to the back end
	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_REPLACE = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef struct packed {
		op_t   op;
		word_t value;
		word_t new_value;
	} req_t;

	// Map a raw command onto an operation; unused codes do nothing
	function automatic op_t decode_cmd(input logic [1:0] cmd);
		op_t op;
		case (cmd)
			CMD_PUSH:    op = OP_PUSH;
			CMD_POP:     op = OP_POP;
			CMD_REPLACE: op = OP_REPLACE;
			default:     op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

@@ sv/lqr_front.sv @@
// Front end: accept requests, decode the command and hand them to the queue.
module lqr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  lqr_pkg::word_t      value,
	input  lqr_pkg::word_t      new_value,
	output logic                req_valid,
	output lqr_pkg::req_t       req,
	input  logic                req_full
);
	import lqr_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	logic  accept;
	logic  handoff;

	// Hold the stage while the queue is full
	assign handoff  = valid_s1 && !req_full;
	assign in_stall = valid_s1 && req_full;
	assign accept   = in_valid && !in_stall;

	// Advance the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (handoff) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the decoded request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.op        <= decode_cmd(cmd);
			req_s1.value     <= value;
			req_s1.new_value <= new_value;
		end
	end

	assign req_valid = valid_s1;
	assign req       = req_s1;

endmodule

@@ sv/lqr_fifo.sv @@
// Two-entry request queue between the front end and the back end.
module lqr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  lqr_pkg::req_t  wr_req,
	output logic           full,
	output logic           rd_valid,
	output lqr_pkg::req_t  rd_req,
	input  logic           rd_take
);
	import lqr_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_req   = slot_q[rd_ptr_q];
	assign push     = wr_valid && !full;
	assign pop      = rd_take && rd_valid;

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_req;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("request queue count out of range");

endmodule

@@ sv/lqr_back.sv @@
// Back end: run queue operations on the entry registers and register the result.
module lqr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  lqr_pkg::req_t  req,
	output logic           req_take,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     status,
	output lqr_pkg::word_t popped_value
);
	import lqr_pkg::*;

	word_t      entries_q [DEPTH];
	idx_t       head_q;
	idx_t       tail_q;
	logic       empty_q;
	logic       out_valid_q;
	logic [1:0] status_q;
	word_t      popped_q;

	logic       live   [DEPTH];
	logic       match  [DEPTH];
	logic       found;
	logic       push_wr;
	idx_t       push_idx;
	logic       repl_wr;
	logic [1:0] status_d;
	word_t      popped_d;
	idx_t       head_d;
	idx_t       tail_d;
	logic       empty_d;

	// Execute when the result register is free or being drained
	assign req_take = req_valid && (!out_valid_q || !out_stall);

	// Compare every live entry against the match word
	always_comb begin
		found = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			live[i]  = !empty_q && (idx_t'(i) >= head_q) && (idx_t'(i) <= tail_q);
			match[i] = live[i] && (entries_q[i] == req.value);
			found    = found | match[i];
		end
	end

	// Work out the next state and the result
	always_comb begin
		status_d = ST_OK;
		popped_d = '0;
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		push_wr  = 1'b0;
		push_idx = '0;
		repl_wr  = 1'b0;
		case (req.op)
			OP_PUSH: begin
				if (empty_q) begin
					head_d   = '0;
					tail_d   = '0;
					empty_d  = 1'b0;
					push_wr  = 1'b1;
					push_idx = '0;
				end else if (tail_q == idx_t'(DEPTH - 1)) begin
					status_d = ST_FULL;
				end else begin
					tail_d   = tail_q + idx_t'(1);
					push_wr  = 1'b1;
					push_idx = tail_q + idx_t'(1);
				end
			end
			OP_POP: begin
				if (empty_q) begin
					status_d = ST_EMPTY;
				end else begin
					popped_d = entries_q[head_q];
					if (head_q == tail_q) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b1;
					end else begin
						head_d = head_q + idx_t'(1);
					end
				end
			end
			OP_REPLACE: begin
				if (empty_q) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_NOMATCH;
				end else begin
					repl_wr = 1'b1;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Update indices and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (req_take) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				empty_q     <= empty_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			status_q <= status_d;
			popped_q <= popped_d;
		end
	end

	// Write pushed word or replacement words into the entries
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (req_take && push_wr && (push_idx == idx_t'(i))) begin
				entries_q[i] <= req.value;
			end else if (req_take && repl_wr && match[i]) begin
				entries_q[i] <= req.new_value;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("empty queue with nonzero indices");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (head_q <= tail_q))
		else $error("head passed tail");

	a_nop_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req.op == OP_NOP) |=> (status_q == ST_OK) && (popped_q == '0))
		else $error("unused command gave a nonzero result");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req.op == OP_POP) && empty_q |=> empty_q && (status_q == ST_EMPTY))
		else $error("pop on empty queue changed state");

endmodule

@@ sv/linear_queue_with_replace_core.sv @@
// Top level of the linear queue with push, pop and replace-all-matches.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------
//  input    | in_valid / in_stall | cmd, value, new_value
//  output   | out_valid/out_stall | status, popped_value
//
// One request per cycle sustained while the output is not stalled; each request gives exactly one result.
// After acceptance a request passes the decode register, the two-entry request
// queue, then the result register in the back end.
// Replace compares all entries in parallel.
// arst_n clears the queue to empty; entry words are not reset.
// A stalled output fills the request queue, then stalls the input.
module linear_queue_with_replace_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     cmd,
	input  lqr_pkg::word_t value,
	input  lqr_pkg::word_t new_value,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     status,
	output lqr_pkg::word_t popped_value
);
	import lqr_pkg::*;

	logic  fe_valid;
	req_t  fe_req;
	logic  q_full;
	logic  q_valid;
	req_t  q_req;
	logic  q_take;

	lqr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.new_value (new_value),
		.req_valid (fe_valid),
		.req       (fe_req),
		.req_full  (q_full)
	);

	lqr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fe_valid),
		.wr_req   (fe_req),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_req   (q_req),
		.rd_take  (q_take)
	);

	lqr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (q_valid),
		.req          (q_req),
		.req_take     (q_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_value (popped_value)
	);

endmodule

@@ test/linear_queue_with_replace_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the linear queue with push, pop and replace-all-matches.
module linear_queue_with_replace_core_tb;
	import lqr_pkg::*;

	// Command code the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 924;

	typedef struct packed {
		logic [1:0] cmd;
		word_t      value;
		word_t      new_value;
		logic       typed;
		logic [1:0] st;
		word_t      popped;
	} dir_row_t;

	typedef struct packed {
		logic [1:0] st;
		word_t      popped;
	} queue_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	word_t      value;
	word_t      new_value;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] status;
	word_t      popped_value;

	// Shadow copy of the queue
	word_t      shadow_words [DEPTH];
	int         shadow_head;
	int         shadow_tail;
	bit         shadow_empty;

	queue_result_t pending_results [$];
	dir_row_t      dir_rows [0:25];
	bit            steady;
	int            fail_count;
	int            n_push, n_pop, n_replace, n_unused;
	int            n_ok, n_full, n_empty, n_nomatch;

	linear_queue_with_replace_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.value        (value),
		.new_value    (new_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_value (popped_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run in case the block hangs
	initial begin
		#2_000_000;
		$display("linear_queue_with_replace_core verification failed");
		$finish;
	end

	// Apply one request to the shadow queue and return its result
	function automatic queue_result_t predict_queue_op(input logic [1:0] c, input word_t v,
			input word_t nv);
		queue_result_t r;
		bit found;
		r.st = ST_OK;
		r.popped = '0;
		case (c)
			CMD_PUSH: begin
				if (shadow_empty) begin
					shadow_head = 0;
					shadow_tail = 0;
					shadow_words[0] = v;
					shadow_empty = 1'b0;
				end else if (shadow_tail >= DEPTH - 1) begin
					r.st = ST_FULL;
				end else begin
					shadow_tail++;
					shadow_words[shadow_tail] = v;
				end
			end
			CMD_POP: begin
				if (shadow_empty) begin
					r.st = ST_EMPTY;
				end else begin
					r.popped = shadow_words[shadow_head];
					if (shadow_head == shadow_tail) begin
						shadow_head = 0;
						shadow_tail = 0;
						shadow_empty = 1'b1;
					end else begin
						shadow_head++;
					end
				end
			end
			CMD_REPLACE: begin
				if (shadow_empty) begin
					r.st = ST_EMPTY;
				end else begin
					found = 1'b0;
					for (int i = shadow_head; i <= shadow_tail; i++) begin
						if (shadow_words[i] == v) begin
							shadow_words[i] = nv;
							found = 1'b1;
						end
					end
					if (!found)
						r.st = ST_NOMATCH;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Pick a word: often a live entry or a corner value, otherwise any word
	function automatic word_t pick_word(input bit prefer_live);
		int roll;
		roll = $urandom_range(0, 99);
		if (prefer_live && !shadow_empty && roll < 60)
			return shadow_words[$urandom_range(shadow_head, shadow_tail)];
		if (roll < 80) begin
			case ($urandom_range(0, 4))
				0: return 32'sh0000_0000;
				1: return 32'sh0000_0001;
				2: return 32'shFFFF_FFFF;
				3: return 32'sh7FFF_FFFF;
				default: return 32'sh8000_0000;
			endcase
		end
		return $urandom;
	endfunction

	// Drive one request, wait for acceptance, then log its expected result
	task automatic issue(input dir_row_t row);
		queue_result_t r;
		while (!steady && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= row.cmd;
		value     <= row.value;
		new_value <= row.new_value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = predict_queue_op(row.cmd, row.value, row.new_value);
		if (row.typed) begin
			r.st = row.st;
			r.popped = row.popped;
		end
		pending_results.push_back(r);
		case (row.cmd)
			CMD_PUSH:    n_push++;
			CMD_POP:     n_pop++;
			CMD_REPLACE: n_replace++;
			default:     n_unused++;
		endcase
		@(negedge clk);
	endtask

	// Stall the output side at random, except in the steady stretch
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= !steady && ($urandom_range(0, 99) < 38);
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		queue_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: status %0d, popped_value %0d",
					status, popped_value);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$error("status mismatch: expected %0d, actual %0d", e.st, status);
					fail_count++;
				end
				if (popped_value !== e.popped) begin
					$error("popped_value mismatch: expected %0d, actual %0d",
						e.popped, popped_value);
					fail_count++;
				end
				case (status)
					ST_OK:    n_ok++;
					ST_FULL:  n_full++;
					ST_EMPTY: n_empty++;
					default:  n_nomatch++;
				endcase
			end
		end
	end

	initial begin
		dir_row_t row;
		int rand_done;
		int mode;
		int roll;
		int push_pct;
		int pop_pct;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_PUSH;
		value     <= '0;
		new_value <= '0;
		steady      = 1'b0;
		fail_count  = 0;
		shadow_head = 0;
		shadow_tail = 0;
		shadow_empty = 1'b1;
		foreach (shadow_words[i])
			shadow_words[i] = '0;

		// Directed requests: empty cases, fill to full, replace, drain
		dir_rows = '{
			'{CMD_POP,     32'sh0,         32'sh0,         1'b1, ST_EMPTY,   32'sh0},
			'{CMD_REPLACE, 32'sh1,         32'sh2,         1'b1, ST_EMPTY,   32'sh0},
			'{CMD_UNUSED,  32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh7FFF_FFFF, 32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh8000_0000, 32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'shFFFF_FFFF, 32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh0,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh5,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh5,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh7,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh9,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_PUSH,    32'sh1,         32'sh0,         1'b1, ST_FULL,    32'sh0},
			'{CMD_REPLACE, 32'sh5,         32'shDEAD_BEEF, 1'b0, ST_OK,      32'sh0},
			'{CMD_REPLACE, 32'sh3039,      32'sh1,         1'b1, ST_NOMATCH, 32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b1, ST_OK,      32'sh7FFF_FFFF},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b1, ST_OK,      32'sh8000_0000},
			'{CMD_PUSH,    32'sh3,         32'sh0,         1'b1, ST_FULL,    32'sh0},
			'{CMD_REPLACE, 32'sh8000_0000, 32'sh1,         1'b1, ST_NOMATCH, 32'sh0},
			'{CMD_REPLACE, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 1'b0, ST_OK,      32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b0, ST_OK,      32'sh0},
			'{CMD_POP,     32'sh0,         32'sh0,         1'b1, ST_EMPTY,   32'sh0}
		};

		// Hold reset, then release it
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i]);

		// Random requests in bursts that lean toward filling, draining or mixing
		rand_done = 0;
		mode = 0;
		while (rand_done < RANDOM_REQUESTS) begin
			if (rand_done % 40 == 0)
				mode = $urandom_range(0, 2);
			steady = (rand_done >= 400 && rand_done < 550);
			push_pct = (mode == 0) ? 55 : (mode == 1) ? 20 : 35;
			pop_pct  = (mode == 1) ? 55 : (mode == 0) ? 20 : 35;
			roll = $urandom_range(0, 99);
			row.typed = 1'b0;
			row.st = ST_OK;
			row.popped = '0;
			row.new_value = pick_word(1'b0);
			if (roll < 4) begin
				row.cmd = CMD_UNUSED;
				row.value = $urandom;
			end else if (roll < 4 + push_pct) begin
				row.cmd = CMD_PUSH;
				row.value = pick_word(1'b1);
			end else if (roll < 4 + push_pct + pop_pct) begin
				row.cmd = CMD_POP;
				row.value = $urandom;
			end else begin
				row.cmd = CMD_REPLACE;
				row.value = pick_word(1'b1);
			end
			issue(row);
			rand_done++;
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// Drain outstanding results, then allow the pipeline to settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d push, %0d pop, %0d replace and %0d unused-code requests",
			n_push, n_pop, n_replace, n_unused);
		$display("Results: %0d ok, %0d full, %0d empty, %0d no match; %0d mismatches",
			n_ok, n_full, n_empty, n_nomatch, fail_count);
		if (fail_count == 0)
			$display("linear_queue_with_replace_core verification clean");
		else
			$display("linear_queue_with_replace_core verification failed");
		$finish;
	end

endmodule
